// File: hw/rtl/amqf_pkg.sv
// ============================================================================
// amqf_pkg
// Shared types, character constants and hex helpers for the meter-query framer.
// ============================================================================
package amqf_pkg;

    // Field widths
    localparam int UNIT_W  = 5;
    localparam int ADDR_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;

    // Frame layout
    localparam int ECHO_LEN  = 6;          // chars after ':' that echo the request
    localparam int MIN_COUNT = ECHO_LEN + 3; // echo + two checksum digits + CR
    localparam int REQ_LEN   = 11;

    // Line characters
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36;
    localparam logic [BYTE_W-1:0] CH_FIVE  = 8'h35;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    // Input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_REQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STAT = 2'd2;

    // Frame status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_ECHO      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NONHEX    = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISMATCH  = 3'd3;
    localparam logic [STAT_W-1:0] ST_TOO_SHORT = 3'd4;
    localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd5;

    typedef struct packed {
        logic                opcode;
        logic [ADDR_W-1:0]   reg_address;
        logic [BYTE_W-1:0]   rx_byte;
    } t_in_req;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [STAT_W-1:0]   status;
        logic                last;
    } t_out_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic take;       // capture the accepted request
        logic start;      // begin a new query
        logic rx;         // process one received byte (not a frame end)
        logic end_check;  // frame end: length / echo verdict
        logic rd_hi;      // read high checksum digit from store
        logic rd_lo;      // capture high digit, read low digit
        logic judge;      // decode checksum, set status and payload length
        logic rd_pay;     // read payload byte at index
        logic emit_req;
        logic emit_pay;
        logic emit_stat;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_start;
        logic frame_end;
        logic early_err;
        logic pay_go;
        logic pay_last;
        logic req_last;
        logic out_free;
    } t_sts;

    // Uppercase hex character of a nibble
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
        logic [BYTE_W-1:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'b0, v};
        end else begin
            r = 8'h37 + {4'b0, v};
        end
        return r;
    endfunction

    // Hex digit decode: {valid, nibble}; both cases accepted
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    // Character i of the echo part: unit id, '6' '5', register address
    function automatic logic [BYTE_W-1:0] echo_char(input logic [2:0]        i,
                                                    input logic [UNIT_W-1:0] uid,
                                                    input logic [ADDR_W-1:0] addr);
        logic [BYTE_W-1:0] r;
        case (i)
            3'd0:    r = hex_char({3'b000, uid[4]});
            3'd1:    r = hex_char(uid[3:0]);
            3'd2:    r = CH_SIX;
            3'd3:    r = CH_FIVE;
            3'd4:    r = hex_char({2'b00, addr[5:4]});
            default: r = hex_char(addr[3:0]);
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/amqf_ctrl.sv
// ============================================================================
// amqf_ctrl
// Sequencer: accepts one request at a time and steps the datapath through
// request emission, byte handling, checksum check and payload readout.
// ============================================================================
module amqf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  amqf_pkg::t_sts i_sts,
    output amqf_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REQ,
        S_HI,
        S_LO,
        S_PAYR,
        S_PAYW,
        S_STAT
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_start) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_REQ;
                end else if (i_sts.frame_end) begin
                    o_cmd.end_check = 1'b1;
                    if (i_sts.early_err) begin
                        n_state = S_STAT;
                    end else begin
                        o_cmd.rd_hi = 1'b1;
                        n_state     = S_HI;
                    end
                end else begin
                    o_cmd.rx = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_REQ: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_req = 1'b1;
                    if (i_sts.req_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_HI: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_LO;
            end
            S_LO: begin
                o_cmd.judge = 1'b1;
                n_state     = i_sts.pay_go ? S_PAYR : S_STAT;
            end
            S_PAYR: begin
                o_cmd.rd_pay = 1'b1;
                n_state      = S_PAYW;
            end
            S_PAYW: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_pay = 1'b1;
                    n_state        = i_sts.pay_last ? S_STAT : S_PAYR;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_stat = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_stall;

    // Only one result loaded into the output register per cycle
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.emit_req, o_cmd.emit_pay, o_cmd.emit_stat}))
        else $error("amqf_ctrl: more than one emit command");

    // No result is produced while a new request may be accepted
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !(o_cmd.emit_req || o_cmd.emit_pay || o_cmd.emit_stat))
        else $error("amqf_ctrl: emit while accepting");

    // A captured request is always executed in the following cycle
    a_take_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> (o_cmd.start || o_cmd.rx || o_cmd.end_check))
        else $error("amqf_ctrl: request not executed");

endmodule

// File: hw/rtl/amqf_dp.sv
// ============================================================================
// amqf_dp
// Datapath: unit id register, link state, frame store, checksum logic and the
// output register.
// ============================================================================
module amqf_dp #(
    parameter int MAX_FRAME_BODY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [amqf_pkg::UNIT_W-1:0] i_cfg_data,
    input  amqf_pkg::t_in_req        i_in_req,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output amqf_pkg::t_out_rsp       o_out_rsp,
    input  amqf_pkg::t_cmd           i_cmd,
    output amqf_pkg::t_sts           o_sts
);

    localparam int CAP   = amqf_pkg::ECHO_LEN + MAX_FRAME_BODY + 1;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int AW    = $clog2(MAX_FRAME_BODY);
    localparam int BW    = amqf_pkg::BYTE_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_COLLECT
    } t_phase;

    // Configuration and captured request
    logic [amqf_pkg::UNIT_W-1:0] r_unit_id;
    amqf_pkg::t_in_req           r_in;

    // Link state
    t_phase                      r_phase;
    logic [amqf_pkg::ADDR_W-1:0] r_exp_addr;
    logic [CNT_W-1:0]            r_count;
    logic [BW-1:0]               r_sum;
    logic                        r_echo_ok;
    logic [BW-1:0]               r_prev;

    // Frame check and readout
    logic [BW-1:0]               r_req_cs;
    logic [BW-1:0]               r_hi;
    logic [amqf_pkg::STAT_W-1:0] r_stat;
    logic [CNT_W-1:0]            r_plen;
    logic [CNT_W-1:0]            r_idx;

    // Frame store
    logic [BW-1:0]               r_mem [MAX_FRAME_BODY];
    logic [BW-1:0]               r_rd_data;

    // Output register
    logic                        r_out_valid;
    amqf_pkg::t_out_rsp          r_out;

    logic [BW-1:0]               c;
    logic                        out_free;
    logic                        store_we;
    logic [CNT_W-1:0]            body_idx;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [BW-1:0]               start_sum;
    logic [BW-1:0]               start_cs;
    logic [BW-1:0]               req_char;
    logic [amqf_pkg::STAT_W-1:0] early_st;
    logic [4:0]                  hv;
    logic [4:0]                  lv;
    logic [BW-1:0]               body_sum;
    logic [BW-1:0]               want;
    logic [amqf_pkg::STAT_W-1:0] judge_st;

    assign c        = r_in.rx_byte;
    assign out_free = !r_out_valid || !i_out_stall;

    // Checksum of the six echo characters for a new request
    always_comb begin
        start_sum = '0;
        for (int i = 0; i < amqf_pkg::ECHO_LEN; i++) begin
            start_sum = start_sum + amqf_pkg::echo_char(3'(i), r_unit_id, r_in.reg_address);
        end
        start_cs = 8'd0 - start_sum;
    end

    // Request character at the current index
    always_comb begin
        case (r_idx[3:0])
            4'd0:    req_char = amqf_pkg::CH_COLON;
            4'd7:    req_char = amqf_pkg::hex_char(r_req_cs[7:4]);
            4'd8:    req_char = amqf_pkg::hex_char(r_req_cs[3:0]);
            4'd9:    req_char = amqf_pkg::CH_CR;
            4'd10:   req_char = amqf_pkg::CH_LF;
            default: req_char = amqf_pkg::echo_char(3'(r_idx[3:0] - 4'd1), r_unit_id,
                                                    r_exp_addr);
        endcase
    end

    // Body store write for bytes past the echo
    assign body_idx = r_count - CNT_W'(amqf_pkg::ECHO_LEN);
    assign store_we = i_cmd.rx && (r_phase == PH_COLLECT)
                   && (r_count >= CNT_W'(amqf_pkg::ECHO_LEN))
                   && (body_idx < CNT_W'(MAX_FRAME_BODY));

    // Read address: checksum digits or payload index
    assign rd_en = i_cmd.rd_hi || i_cmd.rd_lo || i_cmd.rd_pay;
    always_comb begin
        if (i_cmd.rd_hi) begin
            rd_addr = AW'(r_count - CNT_W'(amqf_pkg::MIN_COUNT));
        end else if (i_cmd.rd_lo) begin
            rd_addr = AW'(r_count - CNT_W'(amqf_pkg::MIN_COUNT - 1));
        end else begin
            rd_addr = r_idx[AW-1:0];
        end
    end

    // Length and echo verdict at frame end
    always_comb begin
        if (r_count > CNT_W'(amqf_pkg::ECHO_LEN + MAX_FRAME_BODY)) begin
            early_st = amqf_pkg::ST_TOO_LONG;
        end else if (r_count < CNT_W'(amqf_pkg::MIN_COUNT)) begin
            early_st = amqf_pkg::ST_TOO_SHORT;
        end else if (!r_echo_ok) begin
            early_st = amqf_pkg::ST_ECHO;
        end else begin
            early_st = amqf_pkg::ST_OK;
        end
    end

    // Checksum verdict: high digit in r_hi, low digit in read data; the
    // character before LF is always CR
    always_comb begin
        hv       = amqf_pkg::hex_value(r_hi);
        lv       = amqf_pkg::hex_value(r_rd_data);
        body_sum = r_sum - r_hi - r_rd_data - amqf_pkg::CH_CR;
        want     = 8'd0 - body_sum;
        if (!hv[4] || !lv[4]) begin
            judge_st = amqf_pkg::ST_NONHEX;
        end else if (want != {hv[3:0], lv[3:0]}) begin
            judge_st = amqf_pkg::ST_MISMATCH;
        end else begin
            judge_st = amqf_pkg::ST_OK;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.is_start  = (r_in.opcode == amqf_pkg::OP_START);
        o_sts.frame_end = (r_phase == PH_COLLECT) && (c == amqf_pkg::CH_LF)
                       && (r_prev == amqf_pkg::CH_CR);
        o_sts.early_err = (early_st != amqf_pkg::ST_OK);
        o_sts.pay_go    = (judge_st == amqf_pkg::ST_OK)
                       && (r_count != CNT_W'(amqf_pkg::MIN_COUNT));
        o_sts.pay_last  = ((r_idx + CNT_W'(1)) == r_plen);
        o_sts.req_last  = (r_idx == CNT_W'(amqf_pkg::REQ_LEN - 1));
        o_sts.out_free  = out_free;
    end

    // Captured request (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_in <= i_in_req;
        end
    end

    // Frame store and its registered read port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_mem[body_idx[AW-1:0]] <= c;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Check and readout payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_cs <= start_cs;
        end
        if (i_cmd.rd_lo) begin
            r_hi <= r_rd_data;
        end
        if (i_cmd.end_check) begin
            r_stat <= early_st;
        end else if (i_cmd.judge) begin
            r_stat <= judge_st;
            r_plen <= r_count - CNT_W'(amqf_pkg::MIN_COUNT);
        end
        if (i_cmd.start || i_cmd.judge) begin
            r_idx <= '0;
        end else if (i_cmd.emit_req || i_cmd.emit_pay) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // Link state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_id  <= '0;
            r_phase    <= PH_IDLE;
            r_exp_addr <= '0;
            r_count    <= '0;
            r_sum      <= '0;
            r_echo_ok  <= 1'b1;
            r_prev     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_unit_id <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_phase    <= PH_WAIT;
                r_exp_addr <= r_in.reg_address;
                r_count    <= '0;
                r_sum      <= '0;
                r_echo_ok  <= 1'b1;
                r_prev     <= '0;
            end else if (i_cmd.end_check) begin
                r_phase <= PH_IDLE;
            end else if (i_cmd.rx) begin
                case (r_phase)
                    PH_WAIT: begin
                        if (c == amqf_pkg::CH_COLON) begin
                            r_phase   <= PH_COLLECT;
                            r_count   <= '0;
                            r_sum     <= '0;
                            r_echo_ok <= 1'b1;
                            r_prev    <= amqf_pkg::CH_COLON;
                        end
                    end
                    PH_COLLECT: begin
                        if (r_count < CNT_W'(amqf_pkg::ECHO_LEN)) begin
                            if (c != amqf_pkg::echo_char(r_count[2:0], r_unit_id,
                                                         r_exp_addr)) begin
                                r_echo_ok <= 1'b0;
                            end
                        end
                        r_sum <= r_sum + c;
                        if (r_count < CNT_W'(CAP)) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_prev <= c;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_req || i_cmd.emit_pay || i_cmd.emit_stat) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_req) begin
            r_out.kind      <= amqf_pkg::KIND_REQ;
            r_out.data_byte <= req_char;
            r_out.status    <= amqf_pkg::ST_OK;
            r_out.last      <= o_sts.req_last;
        end else if (i_cmd.emit_pay) begin
            r_out.kind      <= amqf_pkg::KIND_PAY;
            r_out.data_byte <= r_rd_data;
            r_out.status    <= amqf_pkg::ST_OK;
            r_out.last      <= 1'b0;
        end else if (i_cmd.emit_stat) begin
            r_out.kind      <= amqf_pkg::KIND_STAT;
            r_out.data_byte <= '0;
            r_out.status    <= r_stat;
            r_out.last      <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // A result is only loaded when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_req || i_cmd.emit_pay || i_cmd.emit_stat) |-> out_free)
        else $error("amqf_dp: output register overwritten");

    // Character counter saturates at its cap
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAP))
        else $error("amqf_dp: character count past cap");

    // Payload readout only after a frame that passed every check
    a_pay_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_pay |-> (r_stat == amqf_pkg::ST_OK))
        else $error("amqf_dp: payload emitted from a bad frame");

endmodule

// File: hw/rtl/ascii_meter_query_framer.sv
// ============================================================================
// ascii_meter_query_framer
// Master side of an ASCII meter-query link: builds the 11-character request
// and checks / unpacks the meter's reply frame.
// ============================================================================
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_req  (t_in_req)
//  out     | output    | o_out_valid / i_out_stall | o_out_rsp (t_out_rsp)
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_data (unit id)
//
//  One request is handled at a time. A received byte that does not end a
//  frame is captured and then executed; a start also emits the 11 request
//  characters. A frame end gives the status alone when length or echo
//  fails, else checks the checksum digits, then reads each payload byte via
//  the store's single registered read port and emits it, then the status.
//  Reset is synchronous and active low; the frame store is not cleared.
//  Output stalls hold the sequencer in place; the result register keeps its
//  contents until taken.
//
module ascii_meter_query_framer #(
    parameter int MAX_FRAME_BODY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [amqf_pkg::UNIT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  amqf_pkg::t_in_req           i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output amqf_pkg::t_out_rsp          o_out_rsp
);

    amqf_pkg::t_cmd cmd;
    amqf_pkg::t_sts sts;

    // Sequencer
    amqf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    amqf_dp #(
        .MAX_FRAME_BODY (MAX_FRAME_BODY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// File: tb/tb_ascii_meter_query_framer.sv
// ============================================================================
// tb_ascii_meter_query_framer
// Self-checking bench for the meter-query framer. A predictor class follows
// every accepted request and holds the results it implies; each result the
// block hands out is compared field by field with the oldest one held.
// Stimulus is a short directed opening, then random query / reply exchanges
// with corrupted echoes, bad checksums, short and long frames, noise bytes and
// abandoned frames, under random idling on both channels.
// ============================================================================
module tb_ascii_meter_query_framer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT_W      = amqf_pkg::UNIT_W;
    localparam int ADDR_W      = amqf_pkg::ADDR_W;
    localparam int BYTE_W      = amqf_pkg::BYTE_W;
    localparam int FRAME_BODY  = 16;
    localparam int COUNT_LIMIT = amqf_pkg::ECHO_LEN + FRAME_BODY + 1;
    localparam int ITEM_TARGET = 420;
    localparam int CALM_POINT  = 360;
    localparam int SETTLE      = 8;      // cycles for a byte still in flight
    localparam int WATCHDOG    = 3000;   // cycles without any handshake

    typedef enum logic [1:0] {LINK_IDLE, LINK_WAIT, LINK_COLLECT} link_phase_e;

    // ------------------------------------------------------------------------
    // Predictor and store of expected results
    // ------------------------------------------------------------------------
    class reply_tracker;
        logic [UNIT_W-1:0]  unit_id;
        link_phase_e        phase;
        logic [ADDR_W-1:0]  query_addr;
        int unsigned        char_count;
        logic [BYTE_W-1:0]  line_sum;
        bit                 echo_good;
        logic [BYTE_W-1:0]  prev_char;
        logic [BYTE_W-1:0]  body_bytes [FRAME_BODY];
        amqf_pkg::t_out_rsp awaited [$];
        int                 fails;

        function new();
            unit_id    = '0;
            phase      = LINK_IDLE;
            query_addr = '0;
            char_count = 0;
            line_sum   = '0;
            echo_good  = 1'b1;
            prev_char  = '0;
            fails      = 0;
        endfunction

        // Uppercase hex character of a nibble
        function logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
            return (v < 4'd10) ? 8'h30 + BYTE_W'(v) : 8'h41 + BYTE_W'(v) - 8'd10;
        endfunction

        // Nibble value of a hex character, -1 when not a digit
        function int hex_decode(input logic [BYTE_W-1:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
            return -1;
        endfunction

        // Character i of the echo that follows ':'
        function logic [BYTE_W-1:0] echo_digit(input int i);
            case (i)
                0:       return hex_digit({3'b000, unit_id[4]});
                1:       return hex_digit(unit_id[3:0]);
                2:       return amqf_pkg::CH_SIX;
                3:       return amqf_pkg::CH_FIVE;
                4:       return hex_digit({2'b00, query_addr[5:4]});
                default: return hex_digit(query_addr[3:0]);
            endcase
        endfunction

        function void push(input logic [amqf_pkg::KIND_W-1:0] kind,
                           input logic [BYTE_W-1:0] data,
                           input logic [amqf_pkg::STAT_W-1:0] st, input logic last);
            amqf_pkg::t_out_rsp r;
            r.kind      = kind;
            r.data_byte = data;
            r.status    = st;
            r.last      = last;
            awaited     = {awaited, r};
        endfunction

        // CR LF seen: judge the frame, queue payload and status
        function void close_frame();
            int unsigned                 n;
            logic [amqf_pkg::STAT_W-1:0] st;
            int unsigned                 plen;
            logic [BYTE_W-1:0]           hi, lo, cr, body, want;
            int                          h, l;
            n     = char_count;
            st    = amqf_pkg::ST_OK;
            plen  = 0;
            phase = LINK_IDLE;
            if (n > amqf_pkg::ECHO_LEN + FRAME_BODY) begin
                st = amqf_pkg::ST_TOO_LONG;
            end else if (n < amqf_pkg::MIN_COUNT) begin
                st = amqf_pkg::ST_TOO_SHORT;
            end else if (!echo_good) begin
                st = amqf_pkg::ST_ECHO;
            end else begin
                hi = body_bytes[n - amqf_pkg::ECHO_LEN - 3];
                lo = body_bytes[n - amqf_pkg::ECHO_LEN - 2];
                cr = body_bytes[n - amqf_pkg::ECHO_LEN - 1];
                h  = hex_decode(hi);
                l  = hex_decode(lo);
                if (h < 0 || l < 0) begin
                    st = amqf_pkg::ST_NONHEX;
                end else begin
                    body = line_sum - hi - lo - cr;
                    want = 8'd0 - body;
                    if (want != BYTE_W'((h << 4) | l)) st = amqf_pkg::ST_MISMATCH;
                    else plen = n - amqf_pkg::ECHO_LEN - 3;
                end
            end
            for (int i = 0; i < plen; i++)
                push(amqf_pkg::KIND_PAY, body_bytes[i], amqf_pkg::ST_OK, 1'b0);
            push(amqf_pkg::KIND_STAT, '0, st, 1'b1);
        endfunction

        // Accepted request: advance the link state, queue what it causes
        function void note_request(input amqf_pkg::t_in_req r);
            logic [BYTE_W-1:0] line [amqf_pkg::REQ_LEN];
            logic [BYTE_W-1:0] sum;
            logic [BYTE_W-1:0] c;
            int unsigned       idx;
            if (r.opcode == amqf_pkg::OP_START) begin
                query_addr = r.reg_address;
                sum        = '0;
                line[0]    = amqf_pkg::CH_COLON;
                for (int i = 0; i < amqf_pkg::ECHO_LEN; i++) begin
                    line[i+1] = echo_digit(i);
                    sum       = sum + line[i+1];
                end
                sum      = 8'd0 - sum;
                line[7]  = hex_digit(sum[7:4]);
                line[8]  = hex_digit(sum[3:0]);
                line[9]  = amqf_pkg::CH_CR;
                line[10] = amqf_pkg::CH_LF;
                for (int i = 0; i < amqf_pkg::REQ_LEN; i++)
                    push(amqf_pkg::KIND_REQ, line[i], amqf_pkg::ST_OK,
                         i == amqf_pkg::REQ_LEN - 1);
                phase      = LINK_WAIT;
                char_count = 0;
                line_sum   = '0;
                echo_good  = 1'b1;
                prev_char  = '0;
                return;
            end
            c = r.rx_byte;
            if (phase == LINK_WAIT) begin
                if (c == amqf_pkg::CH_COLON) begin
                    phase      = LINK_COLLECT;
                    char_count = 0;
                    line_sum   = '0;
                    echo_good  = 1'b1;
                    prev_char  = amqf_pkg::CH_COLON;
                end
                return;
            end
            if (phase != LINK_COLLECT) return;
            if (c == amqf_pkg::CH_LF && prev_char == amqf_pkg::CH_CR) begin
                close_frame();
                return;
            end
            if (char_count < amqf_pkg::ECHO_LEN) begin
                if (c != echo_digit(char_count)) echo_good = 1'b0;
            end else begin
                idx = char_count - amqf_pkg::ECHO_LEN;
                if (idx < FRAME_BODY) body_bytes[idx] = c;
            end
            line_sum = line_sum + c;
            if (char_count < COUNT_LIMIT) char_count++;
            prev_char = c;
        endfunction

        function void check_result(input amqf_pkg::t_out_rsp got);
            amqf_pkg::t_out_rsp e;
            if (awaited.size() == 0) begin
                $error("unexpected result: kind %0d data %0h status %0d last %0d",
                       got.kind, got.data_byte, got.status, got.last);
                fails++;
                return;
            end
            e = awaited.pop_front();
            if (got.kind !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, got.kind);
                fails++;
            end
            if (got.data_byte !== e.data_byte) begin
                $error("data_byte: expected %0h, actual %0h", e.data_byte, got.data_byte);
                fails++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                fails++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, got.last);
                fails++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block inputs and the instance
    // ------------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [UNIT_W-1:0]  i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    amqf_pkg::t_in_req  i_in_req    = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    amqf_pkg::t_out_rsp o_out_rsp;

    reply_tracker tracker;
    int           items_sent = 0;
    bit           calm       = 1'b0;   // no idling in the closing stretch
    bit           gaps_on    = 1'b1;

    always #5 i_clk = ~i_clk;

    ascii_meter_query_framer #(
        .MAX_FRAME_BODY (FRAME_BODY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // ------------------------------------------------------------------------
    // Result side: check accepted results, stall in random bursts
    // ------------------------------------------------------------------------
    int stall_left  = 0;
    bit stall_mode  = 1'b1;
    int stall_epoch = 0;

    always @(posedge i_clk) begin
        logic hold;
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_result(o_out_rsp);
        stall_epoch = stall_epoch + 1;
        if (stall_epoch % 50 == 0) stall_mode = ($urandom_range(0, 2) != 0);
        hold = 1'b0;
        if (!calm && stall_mode) begin
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                hold       = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                hold       = 1'b1;
            end
        end
        i_out_stall <= hold;
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no handshake on either channel
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("ascii_meter_query_framer: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    function automatic amqf_pkg::t_in_req start_req(input logic [ADDR_W-1:0] addr);
        amqf_pkg::t_in_req r;
        r.opcode      = amqf_pkg::OP_START;
        r.reg_address = addr;
        r.rx_byte     = BYTE_W'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic amqf_pkg::t_in_req byte_req(input logic [BYTE_W-1:0] c);
        amqf_pkg::t_in_req r;
        r.opcode      = amqf_pkg::OP_BYTE;
        r.reg_address = ADDR_W'($urandom_range(0, 63));
        r.rx_byte     = c;
        return r;
    endfunction

    // Present one request, optionally after an idle burst; return once taken
    task automatic send_req(input amqf_pkg::t_in_req r, input bit counted);
        int gap;
        gap = 0;
        if (!calm && gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        tracker.note_request(r);
        if (counted) items_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] c, input bit counted);
        send_req(byte_req(c), counted);
    endtask

    // Hold off until every expected result is in and a byte has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_unit(input logic [UNIT_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        tracker.unit_id = v;
        i_cfg_we <= 1'b0;
    endtask

    // Checksum digit text, A-F sometimes in lower case
    function automatic logic [BYTE_W-1:0] sum_digit(input logic [3:0] v);
        logic [BYTE_W-1:0] c;
        c = tracker.hex_digit(v);
        if (v >= 4'd10 && $urandom_range(0, 1) == 1) c = c + 8'h20;
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex();
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(0, 255));
        while (tracker.hex_decode(c) >= 0 || c == amqf_pkg::CH_CR
               || c == amqf_pkg::CH_LF);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] payload_char();
        logic [BYTE_W-1:0] specials [4] = '{amqf_pkg::CH_COLON, amqf_pkg::CH_CR,
                                            8'h00, 8'hFF};
        if ($urandom_range(0, 7) == 0) return specials[$urandom_range(0, 3)];
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Meter reply to the current query; short replies carry at most seven characters after ':' before CR LF
    task automatic send_reply(input int pay_len, input bit bad_echo, input bit bad_hex,
                              input bit bad_sum, input bit short_frame);
        logic [BYTE_W-1:0] line [$];
        logic [BYTE_W-1:0] c, total, cks, hi, lo;
        int                spot, k;
        line = {line, amqf_pkg::CH_COLON};
        spot = bad_echo ? $urandom_range(0, amqf_pkg::ECHO_LEN - 1) : -1;
        k    = short_frame ? $urandom_range(0, amqf_pkg::MIN_COUNT - 2)
                           : amqf_pkg::ECHO_LEN;
        total = '0;
        for (int i = 0; i < k; i++) begin
            c = (i < amqf_pkg::ECHO_LEN) ? tracker.echo_digit(i) : payload_char();
            if (i == spot) c = c ^ (8'h01 << $urandom_range(0, 6));
            line  = {line, c};
            total = total + c;
        end
        if (!short_frame) begin
            for (int p = 0; p < pay_len; p++) begin
                c     = payload_char();
                line  = {line, c};
                total = total + c;
            end
            cks = 8'd0 - total;
            if (bad_sum) cks = cks + BYTE_W'($urandom_range(1, 255));
            hi = sum_digit(cks[7:4]);
            lo = sum_digit(cks[3:0]);
            if (bad_hex) begin
                case ($urandom_range(0, 2))
                    0:       hi = non_hex();
                    1:       lo = non_hex();
                    default: begin
                        hi = non_hex();
                        lo = non_hex();
                    end
                endcase
            end
            line = {line, hi, lo};
        end
        line = {line, amqf_pkg::CH_CR, amqf_pkg::CH_LF};
        foreach (line[i]) send_byte(line[i], 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [UNIT_W-1:0] unit_pick [3];
        int                n, plen;
        bit                short_frame, too_long;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bytes while idle, a clean one-byte reply (its checksum may be
        // in lower case), then start while busy and a short reply
        write_unit(5'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_req(start_req(6'd0), 1'b1);
        send_byte(amqf_pkg::CH_CR, 1'b1);
        send_reply(1, 1'b0, 1'b0, 1'b0, 1'b0);
        write_unit(5'd31);
        send_req(start_req(6'd63), 1'b1);
        send_req(start_req(6'd50), 1'b1);
        send_reply(0, 1'b1, 1'b0, 1'b0, 1'b1);

        // Random query / reply exchanges
        unit_pick = '{5'd0, 5'd31, 5'd0};
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > CALM_POINT) calm = 1'b1;
            gaps_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 11) == 0) begin
                unit_pick[2] = UNIT_W'($urandom_range(0, 31));
                write_unit(unit_pick[$urandom_range(0, 2)]);
            end
            // bytes ahead of the next query, to an idle or abandoned link
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
            send_req(start_req(ADDR_W'($urandom_range(0, 63))), 1'b1);
            // line noise ahead of the reply
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(BYTE_W'($urandom_range(0, 'h39)), 1'b0);
            end
            if ($urandom_range(0, 14) == 0) begin
                // partial reply, abandoned by the next start
                send_byte(amqf_pkg::CH_COLON, 1'b1);
                n = $urandom_range(0, 10);
                repeat (n) send_byte(payload_char(), 1'b1);
            end else begin
                short_frame = ($urandom_range(0, 11) == 0);
                too_long    = ($urandom_range(0, 11) == 0);
                plen = too_long ? $urandom_range(FRAME_BODY - 2, FRAME_BODY + 2)
                                : $urandom_range(0, FRAME_BODY - 3);
                send_reply(plen, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                           $urandom_range(0, 9) == 0, short_frame);
            end
        end

        // Closing: everything in, then a settle window
        calm = 1'b1;
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.fails == 0) begin
            $display("ascii_meter_query_framer: match");
        end else begin
            $display("ascii_meter_query_framer: mismatch");
        end
        $finish;
    end

endmodule
